[sv/bmmc_pkg.sv]
// Shared constants and codes for the banked memory map controller.
// No dependencies; the top level uses it through scoped names.
package bmmc_pkg;

  // Default number of switchable work-RAM banks for the 0xD000 window.
  localparam int unsigned WORK_BANKS_DEF = 7;
  localparam int unsigned WORK_BANK_SIZE = 4096;

  localparam int unsigned MAIN_DEPTH  = 32768;
  localparam int unsigned VRAM_DEPTH  = 8192;
  localparam int unsigned PAL_DEPTH   = 64;

  // Bus map
  localparam logic [15:0] ADDR_MAIN_LO = 16'h8000;
  localparam logic [15:0] ADDR_VRAM_HI = 16'h9FFF;
  localparam logic [15:0] ADDR_WORK_LO = 16'hD000;
  localparam logic [15:0] ADDR_WORK_HI = 16'hDFFF;

  // I/O registers
  localparam logic [15:0] ADDR_JOYP  = 16'hFF00;
  localparam logic [15:0] ADDR_SB    = 16'hFF01;
  localparam logic [15:0] ADDR_SC    = 16'hFF02;
  localparam logic [15:0] ADDR_DIV   = 16'hFF04;
  localparam logic [15:0] ADDR_DMA   = 16'hFF46;
  localparam logic [15:0] ADDR_SPEED = 16'hFF4D;
  localparam logic [15:0] ADDR_VBK   = 16'hFF4F;
  localparam logic [15:0] ADDR_HDMA  = 16'hFF55;
  localparam logic [15:0] ADDR_BGPI  = 16'hFF68;
  localparam logic [15:0] ADDR_BGPD  = 16'hFF69;
  localparam logic [15:0] ADDR_OBPI  = 16'hFF6A;
  localparam logic [15:0] ADDR_OBPD  = 16'hFF6B;
  localparam logic [15:0] ADDR_WBK   = 16'hFF70;

  localparam logic [7:0] PAL_IDX_MASK = 8'h3F;
  localparam logic [7:0] FIXED_HIGH   = 8'h80;

  // Where the read byte of a response comes from
  typedef enum logic [2:0] {
    SRC_ZERO  = 3'd0,
    SRC_MAIN  = 3'd1,
    SRC_VRAM  = 3'd2,
    SRC_WORK  = 3'd3,
    SRC_BGP   = 3'd4,
    SRC_OBP   = 3'd5,
    SRC_SPEED = 3'd6,
    SRC_HDMA  = 3'd7
  } rd_src_t;

endpackage

[sv/banked_memory_map_controller_top.sv]
// Banked memory map controller: upper half of the CPU bus, video and work-RAM
// banking, palette ports and a few I/O registers. Depends on bmmc_pkg.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+----------------------
//  command  | start, busy, in_mode/address/write_data/joypad| start && !busy
//  result   | out_valid, out_read_data/cartridge_access/    | strobe, one cycle
//           | out_serial_valid/out_serial_byte              |
//  config   | cfg_valid, cfg_ready, cfg_color_mode          | cfg_valid && cfg_ready
//
// An accepted beat passes through execute, where all memories are read
// or written at once, and its result strobes in the following cycle, taken
// from the synchronous read of the memories.
// A new beat is taken in the cycle the previous result strobes.
// Reset (rst_n low, synchronous) clears control state and color_mode only;
// memory contents stay undefined until written. The receiver cannot stall.
module banked_memory_map_controller_top #(
  parameter int unsigned WORK_BANKS = bmmc_pkg::WORK_BANKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_joypad,
  // result channel
  output logic        out_valid,
  output logic [7:0]  out_read_data,
  output logic        out_cartridge_access,
  output logic        out_serial_valid,
  output logic [7:0]  out_serial_byte,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_color_mode
);

  localparam int unsigned WORK_DEPTH = WORK_BANKS * bmmc_pkg::WORK_BANK_SIZE;
  localparam int unsigned MAIN_AW    = $clog2(bmmc_pkg::MAIN_DEPTH);
  localparam int unsigned VRAM_AW    = $clog2(bmmc_pkg::VRAM_DEPTH);
  localparam int unsigned WORK_AW    = $clog2(WORK_DEPTH);
  localparam int unsigned PAL_AW     = $clog2(bmmc_pkg::PAL_DEPTH);
  localparam logic [2:0]  LAST_BANK  = 3'(WORK_BANKS - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Configuration: always ready; the user must write it only while idle, the block does not enforce this.
  logic color_mode_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      color_mode_r <= cfg_color_mode;
    end
  end

  // Captured command beat
  logic        mode_r;
  logic [15:0] addr_r;
  logic [7:0]  wdata_r;
  logic [7:0]  pad_r;

  logic accept;
  assign busy   = (state_r == S_EXEC);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
      pad_r   <= in_joypad;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Shadow copies of the control bytes kept in the main store. They follow
  // every main-store write to their address, so they always equal the stored
  // byte once it has been written.
  logic       vbk_r;
  logic [2:0] wbk_r;
  logic [7:0] bgpi_r;
  logic [7:0] obpi_r;
  logic [7:0] sb_r;

  // Execute-cycle decode
  logic                is_exec;
  logic                is_cart;
  logic                in_vram_win;
  logic                in_work_win;
  logic                vram_ovl;
  logic                work_ovl;
  logic [2:0]          bank_m1;
  logic [2:0]          bank_sat;
  logic [7:0]          joyp_val;

  logic                main_we;
  logic [MAIN_AW-1:0]  main_addr;
  logic [7:0]          main_wd;
  logic                vram_we;
  logic                work_we;
  logic                bgp_we;
  logic                obp_we;
  logic [VRAM_AW-1:0]  vram_addr;
  logic [WORK_AW-1:0]  work_addr;
  logic [PAL_AW-1:0]   bgp_addr;
  logic [PAL_AW-1:0]   obp_addr;
  logic                serial_hit;
  bmmc_pkg::rd_src_t   src;

  assign is_exec     = (state_r == S_EXEC);
  assign is_cart     = (addr_r < bmmc_pkg::ADDR_MAIN_LO);
  assign in_vram_win = (addr_r >= bmmc_pkg::ADDR_MAIN_LO) && (addr_r <= bmmc_pkg::ADDR_VRAM_HI);
  assign in_work_win = (addr_r >= bmmc_pkg::ADDR_WORK_LO) && (addr_r <= bmmc_pkg::ADDR_WORK_HI);
  assign vram_ovl    = color_mode_r && in_vram_win && vbk_r;
  assign work_ovl    = color_mode_r && in_work_win;

  // Bank 0 reads as bank 1; bank n lives in slot n-1, clamped to the last slot.
  always_comb begin
    bank_m1  = (wbk_r == 3'd0) ? 3'd0 : (wbk_r - 3'd1);
    bank_sat = (bank_m1 > LAST_BANK) ? LAST_BANK : bank_m1;
  end

  assign vram_addr = addr_r[VRAM_AW-1:0];
  assign work_addr = WORK_AW'({bank_sat, addr_r[11:0]});
  assign bgp_addr  = PAL_AW'(bgpi_r & bmmc_pkg::PAL_IDX_MASK);
  assign obp_addr  = PAL_AW'(obpi_r & bmmc_pkg::PAL_IDX_MASK);

  // Joypad merge: one select line low picks its nibble, else all ones.
  always_comb begin
    if (!wdata_r[5] && wdata_r[4]) begin
      joyp_val = wdata_r | {4'h0, pad_r[7:4]};
    end else if (!wdata_r[4] && wdata_r[5]) begin
      joyp_val = wdata_r | {4'h0, pad_r[3:0]};
    end else begin
      joyp_val = wdata_r | 8'h0F;
    end
  end

  always_comb begin
    main_we    = 1'b0;
    main_addr  = addr_r[MAIN_AW-1:0];
    main_wd    = wdata_r;
    vram_we    = 1'b0;
    work_we    = 1'b0;
    bgp_we     = 1'b0;
    obp_we     = 1'b0;
    serial_hit = 1'b0;
    src        = bmmc_pkg::SRC_ZERO;
    if (!is_cart) begin
      if (mode_r) begin
        if (addr_r == bmmc_pkg::ADDR_JOYP) begin
          main_we = 1'b1;
          main_wd = joyp_val;
        end else if (addr_r == bmmc_pkg::ADDR_SC) begin
          serial_hit = 1'b1;
        end else if (addr_r == bmmc_pkg::ADDR_DIV) begin
          main_we = 1'b1;
          main_wd = 8'h00;
        end else if (addr_r == bmmc_pkg::ADDR_DMA) begin
          // drop: DMA copy not modeled
        end else if (!color_mode_r) begin
          main_we = 1'b1;
        end else if (vram_ovl) begin
          vram_we = 1'b1;
        end else if (work_ovl) begin
          work_we = 1'b1;
        end else if (addr_r == bmmc_pkg::ADDR_HDMA) begin
          // drop: HDMA copy not modeled
        end else if (addr_r == bmmc_pkg::ADDR_BGPD) begin
          bgp_we    = 1'b1;
          main_we   = bgpi_r[7];
          main_addr = bmmc_pkg::ADDR_BGPI[MAIN_AW-1:0];
          main_wd   = bgpi_r + 8'd1;
        end else if (addr_r == bmmc_pkg::ADDR_OBPD) begin
          obp_we    = 1'b1;
          main_we   = obpi_r[7];
          main_addr = bmmc_pkg::ADDR_OBPI[MAIN_AW-1:0];
          main_wd   = obpi_r + 8'd1;
        end else begin
          main_we = 1'b1;
        end
      end else begin
        if (addr_r == bmmc_pkg::ADDR_BGPD) begin
          src = bmmc_pkg::SRC_BGP;
        end else if (addr_r == bmmc_pkg::ADDR_OBPD) begin
          src = bmmc_pkg::SRC_OBP;
        end else if (vram_ovl) begin
          src = bmmc_pkg::SRC_VRAM;
        end else if (work_ovl) begin
          src = bmmc_pkg::SRC_WORK;
        end else if (color_mode_r && (addr_r == bmmc_pkg::ADDR_SPEED)) begin
          src = bmmc_pkg::SRC_SPEED;
        end else if (color_mode_r && (addr_r == bmmc_pkg::ADDR_HDMA)) begin
          src = bmmc_pkg::SRC_HDMA;
        end else begin
          src = bmmc_pkg::SRC_MAIN;
        end
      end
    end
  end

  // Track the control bytes on main-store writes.
  always_ff @(posedge clk) begin
    if (is_exec && main_we) begin
      if (main_addr == bmmc_pkg::ADDR_VBK[MAIN_AW-1:0])  vbk_r  <= main_wd[0];
      if (main_addr == bmmc_pkg::ADDR_WBK[MAIN_AW-1:0])  wbk_r  <= main_wd[2:0];
      if (main_addr == bmmc_pkg::ADDR_BGPI[MAIN_AW-1:0]) bgpi_r <= main_wd;
      if (main_addr == bmmc_pkg::ADDR_OBPI[MAIN_AW-1:0]) obpi_r <= main_wd;
      if (main_addr == bmmc_pkg::ADDR_SB[MAIN_AW-1:0])   sb_r   <= main_wd;
    end
  end

  // Memories: one port each, registered read data.
  logic [7:0] main_mem [bmmc_pkg::MAIN_DEPTH];
  logic [7:0] vram_mem [bmmc_pkg::VRAM_DEPTH];
  logic [7:0] work_mem [WORK_DEPTH];
  logic [7:0] bgp_mem  [bmmc_pkg::PAL_DEPTH];
  logic [7:0] obp_mem  [bmmc_pkg::PAL_DEPTH];

  logic [7:0] main_rd_r;
  logic [7:0] vram_rd_r;
  logic [7:0] work_rd_r;
  logic [7:0] bgp_rd_r;
  logic [7:0] obp_rd_r;

  always_ff @(posedge clk) begin
    if (is_exec && main_we) main_mem[main_addr] <= main_wd;
    main_rd_r <= main_mem[main_addr];
  end

  always_ff @(posedge clk) begin
    if (is_exec && vram_we) vram_mem[vram_addr] <= wdata_r;
    vram_rd_r <= vram_mem[vram_addr];
  end

  always_ff @(posedge clk) begin
    if (is_exec && work_we) work_mem[work_addr] <= wdata_r;
    work_rd_r <= work_mem[work_addr];
  end

  always_ff @(posedge clk) begin
    if (is_exec && bgp_we) bgp_mem[bgp_addr] <= wdata_r;
    bgp_rd_r <= bgp_mem[bgp_addr];
  end

  always_ff @(posedge clk) begin
    if (is_exec && obp_we) obp_mem[obp_addr] <= wdata_r;
    obp_rd_r <= obp_mem[obp_addr];
  end

  // Result stage: strobe for one cycle after execute.
  logic              out_valid_r;
  logic              out_cart_r;
  logic              out_serial_valid_r;
  logic [7:0]        out_serial_byte_r;
  bmmc_pkg::rd_src_t src_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= is_exec;
    end
  end

  always_ff @(posedge clk) begin
    if (is_exec) begin
      out_cart_r         <= is_cart;
      out_serial_valid_r <= serial_hit;
      out_serial_byte_r  <= serial_hit ? sb_r : 8'h00;
      src_r              <= src;
    end
  end

  always_comb begin
    case (src_r)
      bmmc_pkg::SRC_MAIN:  out_read_data = main_rd_r;
      bmmc_pkg::SRC_VRAM:  out_read_data = vram_rd_r;
      bmmc_pkg::SRC_WORK:  out_read_data = work_rd_r;
      bmmc_pkg::SRC_BGP:   out_read_data = bgp_rd_r;
      bmmc_pkg::SRC_OBP:   out_read_data = obp_rd_r;
      bmmc_pkg::SRC_SPEED: out_read_data = main_rd_r[0] ? bmmc_pkg::FIXED_HIGH : 8'h00;
      bmmc_pkg::SRC_HDMA:  out_read_data = bmmc_pkg::FIXED_HIGH;
      default:             out_read_data = 8'h00;
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_cartridge_access = out_cart_r;
  assign out_serial_valid     = out_serial_valid_r;
  assign out_serial_byte      = out_serial_byte_r;

endmodule
